// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/trpc_pkg.sv -----
// shared types and constants of the trapezoid peak centroid unit
package trpc_pkg;

  localparam int X_W        = 16;
  localparam int Y_W        = 16;
  localparam int YC_W       = 15;
  localparam int CEN_W      = 24;
  localparam int STAT_W     = 2;
  localparam int SUM_W      = 64;
  localparam int AT_W       = 33;
  localparam int WT_W       = 50;
  localparam int FRAC_OUT_DEF = 8;
  localparam int Q_DEPTH    = 2;

  localparam logic [CEN_W-1:0] CEN_MAX     = 24'h7F_FFFF;
  localparam logic [CEN_W-1:0] CEN_MIN_MAG = 24'h80_0000;

  localparam logic [STAT_W-1:0] STAT_CENTROID  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SINGLE    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_AREA = 2'd2;

  typedef struct packed {
    logic                    single;
    logic signed [X_W-1:0]   x;
    logic [SUM_W-1:0]        area;
    logic [SUM_W-1:0]        weighted;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } back_state_t;

endpackage

// ----- hw/rtl/trapezoid_peak_centroid_unit.sv -----
// trapezoid peak centroid unit top level
// Curve points are taken one per cycle while the front is not stalling. Each point runs
// through a three-stage front (difference, area product, weighted product with the 64-bit
// accumulate); once the last point reaches the third stage the two sums go into a two-entry
// job queue and the front keeps taking the next curve. The back end handles one curve at a
// time: a single-point or zero-area curve raises its beat in the cycle after leaving the
// queue, a weighted centroid after the restoring divider, which produces one quotient bit
// per cycle over the 64 + FRAC_OUT numerator bits, and a finish state. The front stalls input
// only when a last point finds the queue full.
module trapezoid_peak_centroid_unit #(
  parameter int FRAC_OUT = trpc_pkg::FRAC_OUT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [trpc_pkg::X_W-1:0]     in_x_value,
  input  logic signed [trpc_pkg::Y_W-1:0]     in_y_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [trpc_pkg::CEN_W-1:0]   out_centroid,
  output logic [trpc_pkg::STAT_W-1:0]         out_status
);

  logic               push;
  logic               pop;
  trpc_pkg::job_t     push_job;
  trpc_pkg::job_t     head_job;
  trpc_pkg::qstat_t   qstat;

  trpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_x_value (in_x_value),
    .in_y_value (in_y_value),
    .in_last    (in_last),
    .qstat      (qstat),
    .push       (push),
    .push_job   (push_job)
  );

  trpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  trpc_back #(
    .FRAC_OUT (FRAC_OUT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_job     (head_job),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_centroid (out_centroid),
    .out_status   (out_status)
  );

endmodule

// ----- hw/rtl/trpc_front.sv -----
// front end: point intake, trapezoid terms and curve accumulation
module trpc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [trpc_pkg::X_W-1:0]     in_x_value,
  input  logic signed [trpc_pkg::Y_W-1:0]     in_y_value,
  input  logic                                in_last,
  input  trpc_pkg::qstat_t                    qstat,
  output logic                                push,
  output trpc_pkg::job_t                      push_job
);

  logic                                   adv;
  logic [trpc_pkg::YC_W-1:0]              y_cl;
  logic signed [trpc_pkg::X_W:0]          dx_raw;
  logic signed [trpc_pkg::X_W:0]          xs_raw;
  logic [trpc_pkg::Y_W-1:0]               ys_raw;
  logic signed [trpc_pkg::AT_W:0]         at_full;
  logic signed [trpc_pkg::WT_W-1:0]       wt_full;
  logic [trpc_pkg::SUM_W-1:0]             area_sum_nxt;
  logic [trpc_pkg::SUM_W-1:0]             weighted_sum_nxt;

  logic                                   have_prev_r;
  logic signed [trpc_pkg::X_W-1:0]        prev_x_r;
  logic [trpc_pkg::YC_W-1:0]              prev_y_r;
  logic [trpc_pkg::SUM_W-1:0]             area_sum_r;
  logic [trpc_pkg::SUM_W-1:0]             weighted_sum_r;

  logic                                   s1_valid_r, s2_valid_r, s3_valid_r;
  logic                                   s1_last_r, s2_last_r, s3_last_r;
  logic                                   s1_single_r, s2_single_r, s3_single_r;
  logic signed [trpc_pkg::X_W-1:0]        s1_x_r, s2_x_r, s3_x_r;
  logic signed [trpc_pkg::X_W:0]          s1_dx_r;
  logic [trpc_pkg::Y_W-1:0]               s1_ys_r;
  logic signed [trpc_pkg::X_W:0]          s1_xs_r, s2_xs_r;
  logic signed [trpc_pkg::AT_W-1:0]       s2_at_r, s3_at_r;
  logic signed [trpc_pkg::WT_W-1:0]       s3_wt_r;

  always_comb begin
    adv      = !(s3_valid_r && s3_last_r && qstat.full);
    in_stall = !adv;
    y_cl     = in_y_value[trpc_pkg::Y_W-1] ? '0 : in_y_value[trpc_pkg::YC_W-1:0];
    dx_raw   = {in_x_value[trpc_pkg::X_W-1], in_x_value} - {prev_x_r[trpc_pkg::X_W-1], prev_x_r};
    xs_raw   = {in_x_value[trpc_pkg::X_W-1], in_x_value} + {prev_x_r[trpc_pkg::X_W-1], prev_x_r};
    ys_raw   = {1'b0, y_cl} + {1'b0, prev_y_r};
    at_full  = s1_dx_r * $signed({1'b0, s1_ys_r});
    wt_full  = s2_at_r * s2_xs_r;
    area_sum_nxt     = area_sum_r +
                       {{(trpc_pkg::SUM_W-trpc_pkg::AT_W){s3_at_r[trpc_pkg::AT_W-1]}}, s3_at_r};
    weighted_sum_nxt = weighted_sum_r +
                       {{(trpc_pkg::SUM_W-trpc_pkg::WT_W){s3_wt_r[trpc_pkg::WT_W-1]}}, s3_wt_r};
    push              = s3_valid_r && s3_last_r && adv;
    push_job.single   = s3_single_r;
    push_job.x        = s3_x_r;
    push_job.area     = area_sum_nxt;
    push_job.weighted = weighted_sum_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r    <= 1'b0;
      prev_x_r       <= '0;
      prev_y_r       <= '0;
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      s3_valid_r     <= 1'b0;
      area_sum_r     <= '0;
      weighted_sum_r <= '0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      if (in_valid) begin
        have_prev_r <= !in_last;
        prev_x_r    <= in_last ? '0 : in_x_value;
        prev_y_r    <= in_last ? '0 : y_cl;
      end
      if (s3_valid_r) begin
        if (s3_last_r) begin
          area_sum_r     <= '0;
          weighted_sum_r <= '0;
        end else begin
          area_sum_r     <= area_sum_nxt;
          weighted_sum_r <= weighted_sum_nxt;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r   <= in_last;
      s1_single_r <= in_last && !have_prev_r;
      s1_x_r      <= in_x_value;
      s1_dx_r     <= have_prev_r ? dx_raw : '0;
      s1_ys_r     <= ys_raw;
      s1_xs_r     <= xs_raw;
      s2_last_r   <= s1_last_r;
      s2_single_r <= s1_single_r;
      s2_x_r      <= s1_x_r;
      s2_xs_r     <= s1_xs_r;
      s2_at_r     <= at_full[trpc_pkg::AT_W-1:0];
      s3_last_r   <= s2_last_r;
      s3_single_r <= s2_single_r;
      s3_x_r      <= s2_x_r;
      s3_at_r     <= s2_at_r;
      s3_wt_r     <= wt_full;
    end
  end

endmodule

// ----- hw/rtl/trpc_queue.sv -----
// two-entry job queue between front and back
module trpc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  trpc_pkg::job_t      push_job,
  input  logic                pop,
  output trpc_pkg::job_t      head_job,
  output trpc_pkg::qstat_t    qstat
);

  `include "assert_macros.svh"

  localparam int PTR_W = (trpc_pkg::Q_DEPTH > 1) ? $clog2(trpc_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(trpc_pkg::Q_DEPTH + 1);

  trpc_pkg::job_t      mem_r [trpc_pkg::Q_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(trpc_pkg::Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    head_job    = mem_r[rd_ptr_r];
    qstat.full  = (cnt_r == CNT_W'(trpc_pkg::Q_DEPTH));
    qstat.empty = (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `ASSERT_SAME(a_no_overflow, push, !qstat.full, "push into full queue")
  `ASSERT_SAME(a_no_underflow, pop, !qstat.empty, "pop from empty queue")

endmodule

// ----- hw/rtl/trpc_back.sv -----
// back end: special cases, serial centroid divide and result register
module trpc_back #(
  parameter int FRAC_OUT = trpc_pkg::FRAC_OUT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  trpc_pkg::job_t                     head_job,
  input  trpc_pkg::qstat_t                   qstat,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [trpc_pkg::CEN_W-1:0]  out_centroid,
  output logic [trpc_pkg::STAT_W-1:0]        out_status
);

  `include "assert_macros.svh"

  localparam int NUM_W = trpc_pkg::SUM_W + FRAC_OUT;
  localparam int DEN_W = trpc_pkg::SUM_W + 1;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int XS_W  = 32;
  localparam logic signed [XS_W-1:0] XS_MAX = XS_W'(signed'(8388607));
  localparam logic signed [XS_W-1:0] XS_MIN = -XS_W'(signed'(8388608));

  trpc_pkg::back_state_t state_r, state_nxt;

  logic [NUM_W-1:0]                 num_r, num_nxt;
  logic [DEN_W-1:0]                 den_r, den_nxt;
  logic [trpc_pkg::SUM_W-1:0]       rem_r, rem_nxt;
  logic [trpc_pkg::CEN_W-1:0]       q_r, q_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             neg_r, neg_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [trpc_pkg::CEN_W-1:0]       out_centroid_r, out_centroid_nxt;
  logic [trpc_pkg::STAT_W-1:0]      out_status_r, out_status_nxt;

  logic                             wneg, aneg;
  logic [trpc_pkg::SUM_W-1:0]       wmag, amag;
  logic signed [XS_W-1:0]           xsh;
  logic [DEN_W-1:0]                 trial;
  logic                             ge;
  logic                             mag_sat;

  always_comb begin
    state_nxt        = state_r;
    num_nxt          = num_r;
    den_nxt          = den_r;
    rem_nxt          = rem_r;
    q_nxt            = q_r;
    ovf_nxt          = ovf_r;
    neg_nxt          = neg_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r;
    out_centroid_nxt = out_centroid_r;
    out_status_nxt   = out_status_r;
    pop              = 1'b0;

    wneg    = head_job.weighted[trpc_pkg::SUM_W-1];
    aneg    = head_job.area[trpc_pkg::SUM_W-1];
    wmag    = wneg ? '0 - head_job.weighted : head_job.weighted;
    amag    = aneg ? '0 - head_job.area : head_job.area;
    xsh     = XS_W'($signed(head_job.x)) <<< FRAC_OUT;
    trial   = {rem_r, num_r[NUM_W-1]};
    ge      = (trial >= den_r);
    mag_sat = ovf_r || (q_r >= trpc_pkg::CEN_MIN_MAG);

    case (state_r)
      trpc_pkg::ST_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          if (head_job.single) begin
            if (xsh > XS_MAX) begin
              out_centroid_nxt = trpc_pkg::CEN_MAX;
            end else if (xsh < XS_MIN) begin
              out_centroid_nxt = trpc_pkg::CEN_MIN_MAG;
            end else begin
              out_centroid_nxt = xsh[trpc_pkg::CEN_W-1:0];
            end
            out_status_nxt = trpc_pkg::STAT_SINGLE;
            out_valid_nxt  = 1'b1;
            state_nxt      = trpc_pkg::ST_DONE;
          end else if (head_job.area == '0) begin
            out_centroid_nxt = '0;
            out_status_nxt   = trpc_pkg::STAT_ZERO_AREA;
            out_valid_nxt    = 1'b1;
            state_nxt        = trpc_pkg::ST_DONE;
          end else begin
            num_nxt   = NUM_W'(wmag) << FRAC_OUT;
            den_nxt   = {amag, 1'b0};
            rem_nxt   = '0;
            q_nxt     = '0;
            ovf_nxt   = 1'b0;
            neg_nxt   = wneg ^ aneg;
            cnt_nxt   = '0;
            state_nxt = trpc_pkg::ST_DIV;
          end
        end
      end
      trpc_pkg::ST_DIV: begin
        // one quotient bit per cycle, sticky flag for bits beyond the result range
        rem_nxt = ge ? trpc_pkg::SUM_W'(trial - den_r) : trial[trpc_pkg::SUM_W-1:0];
        num_nxt = num_r << 1;
        q_nxt   = {q_r[trpc_pkg::CEN_W-2:0], ge};
        ovf_nxt = ovf_r || q_r[trpc_pkg::CEN_W-1];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = trpc_pkg::ST_FIN;
        end
      end
      trpc_pkg::ST_FIN: begin
        if (neg_r) begin
          out_centroid_nxt = '0 - (mag_sat ? trpc_pkg::CEN_MIN_MAG : q_r);
        end else begin
          out_centroid_nxt = mag_sat ? trpc_pkg::CEN_MAX : q_r;
        end
        out_status_nxt = trpc_pkg::STAT_CENTROID;
        out_valid_nxt  = 1'b1;
        state_nxt      = trpc_pkg::ST_DONE;
      end
      trpc_pkg::ST_DONE: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = trpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = trpc_pkg::ST_IDLE;
      end
    endcase

    out_valid    = out_valid_r;
    out_centroid = out_centroid_r;
    out_status   = out_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trpc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r          <= num_nxt;
    den_r          <= den_nxt;
    rem_r          <= rem_nxt;
    q_r            <= q_nxt;
    ovf_r          <= ovf_nxt;
    neg_r          <= neg_nxt;
    cnt_r          <= cnt_nxt;
    out_centroid_r <= out_centroid_nxt;
    out_status_r   <= out_status_nxt;
  end

  `ASSERT_SAME(a_valid_only_done, out_valid_r, state_r == trpc_pkg::ST_DONE, "result outside done")
  `ASSERT_SAME(a_status_code, out_valid_r, out_status_r == trpc_pkg::STAT_CENTROID || out_status_r == trpc_pkg::STAT_SINGLE || out_status_r == trpc_pkg::STAT_ZERO_AREA, "bad status code")
  `ASSERT_NEXT(a_div_to_fin, state_r == trpc_pkg::ST_DIV && cnt_r == CNT_W'(NUM_W - 1), state_r == trpc_pkg::ST_FIN, "divide did not finish")

endmodule

// ----- tb/sv/tb_trapezoid_peak_centroid_unit.sv -----
// self-checking testbench for the trapezoid peak centroid unit
`timescale 1ns / 100ps

module tb_trapezoid_peak_centroid_unit;
  import trpc_pkg::*;

  localparam int     FRAC_BITS    = FRAC_OUT_DEF;
  localparam int     TOTAL_POINTS = 1050;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 120;
  localparam longint CEN_HI       = 64'sd8388607;
  localparam longint CEN_LO       = -64'sd8388608;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic                  last;
  } curve_point_t;

  typedef struct packed {
    logic signed [CEN_W-1:0] centroid;
    logic [STAT_W-1:0]       status;
  } centroid_beat_t;

  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [X_W-1:0] in_x_value = '0;
  logic signed [Y_W-1:0] in_y_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CEN_W-1:0] out_centroid;
  logic [STAT_W-1:0] out_status;
  logic hold_rx = 1'b0;

  curve_point_t   pending_points[$];
  centroid_beat_t centroid_due_q[$];

  // running state of the curve being summed
  logic                    have_prev = 1'b0;
  logic signed [X_W-1:0]   prev_x = '0;
  logic [YC_W-1:0]         prev_yc = '0;
  logic [SUM_W-1:0]        area_acc = '0;
  logic [SUM_W-1:0]        moment_acc = '0;

  int total_points = 0;
  int points_taken = 0;
  int curves_done = 0;
  int beats_seen = 0;
  int mismatches = 0;
  int held_cycles = 0;
  int n_centroid = 0;
  int n_single = 0;
  int n_zero = 0;
  int burst_left = 0;
  int gap_left = 0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  curve_point_t next_point;

  trapezoid_peak_centroid_unit #(
    .FRAC_OUT(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_x_value(in_x_value),
    .in_y_value(in_y_value),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_centroid(out_centroid),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic signed [CEN_W-1:0] clamp_centroid(input longint v);
    if (v > CEN_HI) return CEN_W'(CEN_HI);
    if (v < CEN_LO) return CEN_W'(CEN_LO);
    return CEN_W'(v);
  endfunction

  // trunc(moment * 2^frac / (2 * area)) on the signed 64-bit sums, area nonzero
  function automatic logic signed [CEN_W-1:0] centroid_quotient(input logic [SUM_W-1:0] mom,
                                                               input logic [SUM_W-1:0] area);
    logic [SUM_W-1:0] mom_mag;
    logic [SUM_W-1:0] area_mag;
    logic [79:0]      q;
    longint           mag;
    logic             neg;
    mom_mag  = mom[SUM_W-1] ? -mom : mom;
    area_mag = area[SUM_W-1] ? -area : area;
    neg      = mom[SUM_W-1] ^ area[SUM_W-1];
    q = ({16'd0, mom_mag} << FRAC_BITS) / {16'd0, area_mag};
    q = q >> 1;
    if (q >= 80'd8388608) mag = 64'sd8388608;
    else mag = longint'(q[63:0]);
    return clamp_centroid(neg ? -mag : mag);
  endfunction

  task automatic take_curve_point(input logic signed [X_W-1:0] x,
                                  input logic signed [Y_W-1:0] y,
                                  input logic last);
    logic [YC_W-1:0] yc;
    longint          dx;
    longint          ysum;
    longint          xsum;
    longint          area_t;
    longint          mom_t;
    centroid_beat_t  beat;
    yc = y[Y_W-1] ? '0 : y[YC_W-1:0];
    if (have_prev) begin
      dx     = longint'(x) - longint'(prev_x);
      ysum   = longint'(yc) + longint'(prev_yc);
      xsum   = longint'(x) + longint'(prev_x);
      area_t = dx * ysum;
      mom_t  = area_t * xsum;
      area_acc   = area_acc + area_t;
      moment_acc = moment_acc + mom_t;
    end
    if (!last) begin
      prev_x    = x;
      prev_yc   = yc;
      have_prev = 1'b1;
    end else begin
      if (!have_prev) begin
        beat.centroid = clamp_centroid(longint'(x) * (64'sd1 <<< FRAC_BITS));
        beat.status   = STAT_SINGLE;
        n_single++;
      end else if (area_acc == '0) begin
        beat.centroid = '0;
        beat.status   = STAT_ZERO_AREA;
        n_zero++;
      end else begin
        beat.centroid = centroid_quotient(moment_acc, area_acc);
        beat.status   = STAT_CENTROID;
        n_centroid++;
      end
      centroid_due_q.push_back(beat);
      curves_done++;
      have_prev  = 1'b0;
      prev_x     = '0;
      prev_yc    = '0;
      area_acc   = '0;
      moment_acc = '0;
    end
  endtask

  task automatic queue_point(input int x, input int y, input bit last);
    curve_point_t p;
    p.x    = x[X_W-1:0];
    p.y    = y[Y_W-1:0];
    p.last = last;
    pending_points.push_back(p);
  endtask

  task automatic make_random_curve();
    int kind;
    int len;
    int step_max;
    int x;
    int y;
    int peak;
    int center;
    int offset;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      queue_point($urandom, $urandom, 1'b1);
    end else if (kind == 1) begin
      len = $urandom_range(2, 8);
      for (int i = 0; i < len; i++) queue_point($urandom, $urandom, i == len - 1);
    end else begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 24) : $urandom_range(2, 8);
      case ($urandom_range(0, 3))
        0: step_max = 1;
        1: step_max = 16;
        2: step_max = 700;
        default: step_max = 8000;
      endcase
      x      = $urandom;
      peak   = $urandom_range(1, 32767);
      center = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) begin
        offset = (i > center) ? i - center : center - i;
        y = (offset > 15) ? 0 : peak >> offset;
        if ($urandom_range(0, 7) == 0) y = -$urandom_range(0, 32768);
        queue_point(x, y, i == len - 1);
        x = x + $urandom_range(1, step_max);
      end
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_curve_point(in_x_value, in_y_value, in_last);
        points_taken++;
      end
      if (in_valid && in_stall) held_cycles++;
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          next_point = pending_points.pop_front();
          in_valid   <= 1'b1;
          in_x_value <= next_point.x;
          in_y_value <= next_point.y;
          in_last    <= next_point.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, overridden by the long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_RANDOM:   out_stall <= hold_rx || ($urandom_range(0, 2) == 0);
        RX_PERIODIC: out_stall <= hold_rx || ((mode_left % 6) < 2);
        default:     out_stall <= hold_rx;
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    centroid_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (centroid_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat centroid %0d status %0d",
                                  out_centroid, out_status));
      end else begin
        want = centroid_due_q.pop_front();
        if (out_centroid !== want.centroid)
          report_mismatch($sformatf("beat %0d centroid %0d, want %0d",
                                    beats_seen, out_centroid, want.centroid));
        if (out_status !== want.status)
          report_mismatch($sformatf("beat %0d status %0d, want %0d",
                                    beats_seen, out_status, want.status));
      end
    end
  end

  // long receiver hold so the job queue fills and the input stalls
  initial begin
    while (beats_seen < 10) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still due", centroid_due_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    // single points at the x extremes and in the middle
    queue_point(-32768, -32768, 1'b1);
    queue_point(32767, 32767, 1'b1);
    queue_point(0, 5, 1'b1);
    // zero area: all y negative, then a vertical step
    queue_point(100, -5, 1'b0);
    queue_point(200, -7, 1'b1);
    queue_point(7, 100, 1'b0);
    queue_point(7, 200, 1'b1);
    // zero area with a nonzero moment
    queue_point(0, 2, 1'b0);
    queue_point(1, 0, 1'b0);
    queue_point(-1, 1, 1'b1);
    // widest span at full height
    queue_point(-32768, 32767, 1'b0);
    queue_point(32767, 32767, 1'b1);
    // near-cancelled areas saturate low and high
    queue_point(0, 2, 1'b0);
    queue_point(32767, 0, 1'b0);
    queue_point(-32768, 1, 1'b1);
    queue_point(0, 32767, 1'b0);
    queue_point(32767, 0, 1'b0);
    queue_point(-1, 32766, 1'b1);
    // plain peak
    queue_point(10, 0, 1'b0);
    queue_point(11, 50, 1'b0);
    queue_point(12, 100, 1'b0);
    queue_point(13, 50, 1'b0);
    queue_point(14, 0, 1'b1);
    while (pending_points.size() < TOTAL_POINTS) make_random_curve();
    total_points = pending_points.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (points_taken < total_points) @(posedge clk);
    while (centroid_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d points in %0d curves: %0d centroids, %0d single, %0d zero area",
             points_taken, curves_done, n_centroid, n_single, n_zero);
    $display("input held off %0d cycles, receiver hold of %0d cycles, %0d mismatches",
             held_cycles, HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/trpc_pkg.sv
hw/rtl/trpc_front.sv
hw/rtl/trpc_queue.sv
hw/rtl/trpc_back.sv
hw/rtl/trapezoid_peak_centroid_unit.sv
tb/sv/tb_trapezoid_peak_centroid_unit.sv
